[sv/pcc_pkg.sv]
package pcc_pkg;

  localparam int SAMPLE_W = 16;
  localparam int XW       = 17;
  localparam int SQ_W     = 31;
  localparam int XY_W     = 32;
  localparam int SX_W     = 33;
  localparam int SXX_W    = 47;
  localparam int SXY_W    = 48;
  localparam int WORD_W   = 64;
  localparam int HALF_W   = 32;
  localparam int PROD_W   = 128;
  localparam int PQ_W     = 126;
  localparam int REM_W    = 127;
  localparam int QUO_W    = 33;
  localparam int RAD_W    = 34;
  localparam int ROOT_W   = 17;
  localparam int SR_W     = 20;
  localparam int STEP_W   = 6;
  localparam int OUT_W    = 16;

  localparam logic [OUT_W-1:0] Q15_MAX = 16'h7FFF;

  typedef struct packed {
    logic signed [XW-1:0]   x;
    logic signed [XW-1:0]   y;
    logic [SQ_W-1:0]        xx;
    logic [SQ_W-1:0]        yy;
    logic signed [XY_W-1:0] xy;
    logic                   last;
  } pair_t;

  typedef struct packed {
    logic              start;
    logic [WORD_W-1:0] a;
    logic [WORD_W-1:0] b;
  } mul_req_t;

  typedef struct packed {
    logic              done;
    logic [PROD_W-1:0] p;
  } mul_rsp_t;

  typedef enum logic [2:0] {
    ST_ACC,
    ST_MUL,
    ST_DIV,
    ST_SQRT,
    ST_DONE
  } back_state_t;

  typedef enum logic [2:0] {
    OP_N_SXX,
    OP_SX_SX,
    OP_N_SYY,
    OP_SY_SY,
    OP_N_SXY,
    OP_SX_SY,
    OP_C_C,
    OP_VX_VY
  } mul_op_t;

endpackage

[sv/pcc_in_if.sv]
interface pcc_in_if;
  import pcc_pkg::*;
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample_x;
  logic signed [SAMPLE_W-1:0] sample_y;
  logic                       last_pair;
  modport source(output valid, sample_x, sample_y, last_pair, input ready);
  modport sink(input valid, sample_x, sample_y, last_pair, output ready);
endinterface

[sv/pcc_out_if.sv]
interface pcc_out_if;
  import pcc_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [OUT_W-1:0] correlation;
  logic                    zero_variance;
  modport source(output valid, correlation, zero_variance, input ready);
  modport sink(input valid, correlation, zero_variance, output ready);
endinterface

[sv/pcc_cfg_if.sv]
interface pcc_cfg_if;
  logic valid;
  logic ready;
  logic negate_first;
  modport source(output valid, negate_first, input ready);
  modport sink(input valid, negate_first, output ready);
endinterface

[sv/pcc_front.sv]
module pcc_front #(
  parameter int SAMPLE_BITS = 16
) (
  input  logic            clk,
  input  logic            rst_n,
  pcc_in_if.sink          in_ch,
  input  logic            negate_first,
  output pcc_pkg::pair_t  pair_o,
  output logic            pair_valid,
  input  logic            pair_ready
);
  import pcc_pkg::*;

  logic signed [SAMPLE_BITS-1:0] xs, ys;
  logic signed [XW-1:0]          x_ext, y_ext, x_use;
  logic signed [2*XW-1:0]        xx_full, yy_full, xy_full;
  logic                          accept;
  logic                          valid_r, valid_nxt;
  pair_t                         pair_r;

  assign xs      = in_ch.sample_x[SAMPLE_BITS-1:0];
  assign ys      = in_ch.sample_y[SAMPLE_BITS-1:0];
  assign x_ext   = XW'(xs);
  assign y_ext   = XW'(ys);
  // The negated minimum sample still fits, since the lane is one bit wider.
  assign x_use   = negate_first ? -x_ext : x_ext;
  assign xx_full = x_use * x_use;
  assign yy_full = y_ext * y_ext;
  assign xy_full = x_use * y_ext;

  assign in_ch.ready = !valid_r || pair_ready;
  assign accept      = in_ch.valid && in_ch.ready;
  assign valid_nxt   = accept || (valid_r && !pair_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pair_r.x    <= x_use;
      pair_r.y    <= y_ext;
      pair_r.xx   <= xx_full[SQ_W-1:0];
      pair_r.yy   <= yy_full[SQ_W-1:0];
      pair_r.xy   <= xy_full[XY_W-1:0];
      pair_r.last <= in_ch.last_pair;
    end
  end

  assign pair_o     = pair_r;
  assign pair_valid = valid_r;

endmodule

[sv/pcc_queue.sv]
module pcc_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  pcc_pkg::pair_t wr_data,
  input  logic           wr_valid,
  output logic           wr_ready,
  output pcc_pkg::pair_t rd_data,
  output logic           rd_valid,
  input  logic           rd_ready
);
  import pcc_pkg::*;

  pair_t      mem [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;
  logic       push, pop;

  assign wr_ready = (count_r != 2'd2);
  assign rd_valid = (count_r != 2'd0);
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;
  assign rd_data  = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? !rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= wr_data;
    end
  end

endmodule

[sv/pcc_mul.sv]
module pcc_mul (
  input  logic              clk,
  input  logic              rst_n,
  input  pcc_pkg::mul_req_t req,
  output pcc_pkg::mul_rsp_t rsp
);
  import pcc_pkg::*;

  // A 64x64 product built from four 32x32 partial products, one per cycle.
  logic [WORD_W-1:0] a_r, b_r;
  logic [1:0]        idx_r, idx_nxt;
  logic              busy_r, busy_nxt;
  logic [WORD_W-1:0] pp_r;
  logic [1:0]        pp_idx_r;
  logic              pp_valid_r, pp_valid_nxt;
  logic [PROD_W-1:0] acc_r, acc_nxt, pp_shift;
  logic              done_r, done_nxt;
  logic [HALF_W-1:0] a_half, b_half;
  logic [1:0]        shift_sel;

  assign a_half    = idx_r[0] ? a_r[WORD_W-1:HALF_W] : a_r[HALF_W-1:0];
  assign b_half    = idx_r[1] ? b_r[WORD_W-1:HALF_W] : b_r[HALF_W-1:0];
  assign shift_sel = {1'b0, pp_idx_r[0]} + {1'b0, pp_idx_r[1]};

  always_comb begin
    case (shift_sel)
      2'd0:    pp_shift = {{WORD_W{1'b0}}, pp_r};
      2'd1:    pp_shift = {{HALF_W{1'b0}}, pp_r, {HALF_W{1'b0}}};
      2'd2:    pp_shift = {pp_r, {WORD_W{1'b0}}};
      default: pp_shift = '0;
    endcase
  end

  always_comb begin
    busy_nxt     = busy_r;
    idx_nxt      = idx_r;
    pp_valid_nxt = busy_r;
    acc_nxt      = acc_r;
    done_nxt     = pp_valid_r && (pp_idx_r == 2'd3);
    if (req.start) begin
      busy_nxt = 1'b1;
      idx_nxt  = 2'd0;
      acc_nxt  = '0;
    end else begin
      if (busy_r) begin
        idx_nxt = idx_r + 2'd1;
        if (idx_r == 2'd3) begin
          busy_nxt = 1'b0;
        end
      end
      if (pp_valid_r) begin
        acc_nxt = acc_r + pp_shift;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r     <= 1'b0;
      pp_valid_r <= 1'b0;
      done_r     <= 1'b0;
      idx_r      <= 2'd0;
    end else begin
      busy_r     <= busy_nxt;
      pp_valid_r <= pp_valid_nxt;
      done_r     <= done_nxt;
      idx_r      <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      a_r <= req.a;
      b_r <= req.b;
    end
    pp_r     <= a_half * b_half;
    pp_idx_r <= idx_r;
    acc_r    <= acc_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.p    = acc_r;

endmodule

[sv/pcc_back.sv]
module pcc_back #(
  parameter int MAX_LENGTH = 65536,
  parameter int CNT_W      = 17
) (
  input  logic              clk,
  input  logic              rst_n,
  input  pcc_pkg::pair_t    pair_i,
  input  logic              pair_valid,
  output logic              pair_ready,
  output pcc_pkg::mul_req_t mul_req,
  input  pcc_pkg::mul_rsp_t mul_rsp,
  pcc_out_if.source         out_ch
);
  import pcc_pkg::*;

  back_state_t              state_r, state_nxt;
  mul_op_t                  op_r, op_nxt;
  logic                     start_r, start_nxt;
  logic [CNT_W-1:0]         cnt_r, cnt_nxt;
  logic signed [SX_W-1:0]   sx_r, sx_nxt, sy_r, sy_nxt;
  logic [SXX_W-1:0]         sxx_r, sxx_nxt, syy_r, syy_nxt;
  logic signed [SXY_W-1:0]  sxy_r, sxy_nxt;
  logic [WORD_W-1:0]        t0_r, t0_nxt, vx_r, vx_nxt, vy_r, vy_nxt, c_r, c_nxt;
  logic [PQ_W-1:0]          c2_r, c2_nxt, p_r, p_nxt;
  logic [REM_W-1:0]         rem_r, rem_nxt;
  logic [QUO_W-1:0]         quo_r, quo_nxt;
  logic [RAD_W-1:0]         rad_r, rad_nxt;
  logic [SR_W-1:0]          srem_r, srem_nxt;
  logic [ROOT_W-1:0]        root_r, root_nxt;
  logic [STEP_W-1:0]        step_r, step_nxt;
  logic [OUT_W-1:0]         res_corr_r, res_corr_nxt;
  logic                     res_zv_r, res_zv_nxt;
  logic                     out_valid_r, out_valid_nxt;
  logic [OUT_W-1:0]         out_corr_r, out_corr_nxt;
  logic                     out_zv_r, out_zv_nxt;

  logic [SX_W-1:0]          sx_mag, sy_mag;
  logic [SXY_W-1:0]         sxy_mag;
  logic [WORD_W-1:0]        c_mag, n_word, p64, p_neg;
  logic [REM_W-1:0]         div_sh, div_dif, p_ext;
  logic                     div_ge;
  logic [SR_W+1:0]          sq_cur, sq_trial, sq_dif;
  logic                     sq_ge;
  logic [ROOT_W-1:0]        root_step, m_pos, m_neg;
  logic [ROOT_W:0]          root_inc;
  logic                     pop;

  assign sx_mag  = sx_r[SX_W-1] ? SX_W'(-sx_r) : sx_r;
  assign sy_mag  = sy_r[SX_W-1] ? SX_W'(-sy_r) : sy_r;
  assign sxy_mag = sxy_r[SXY_W-1] ? SXY_W'(-sxy_r) : sxy_r;
  assign c_mag   = c_r[WORD_W-1] ? -c_r : c_r;
  assign n_word  = WORD_W'(cnt_r);
  assign p64     = mul_rsp.p[WORD_W-1:0];
  assign p_neg   = -p64;

  always_comb begin
    case (op_r)
      OP_N_SXX: begin
        mul_req.a = n_word;
        mul_req.b = WORD_W'(sxx_r);
      end
      OP_SX_SX: begin
        mul_req.a = WORD_W'(sx_mag);
        mul_req.b = WORD_W'(sx_mag);
      end
      OP_N_SYY: begin
        mul_req.a = n_word;
        mul_req.b = WORD_W'(syy_r);
      end
      OP_SY_SY: begin
        mul_req.a = WORD_W'(sy_mag);
        mul_req.b = WORD_W'(sy_mag);
      end
      OP_N_SXY: begin
        mul_req.a = n_word;
        mul_req.b = WORD_W'(sxy_mag);
      end
      OP_SX_SY: begin
        mul_req.a = WORD_W'(sx_mag);
        mul_req.b = WORD_W'(sy_mag);
      end
      OP_C_C: begin
        mul_req.a = c_mag;
        mul_req.b = c_mag;
      end
      OP_VX_VY: begin
        mul_req.a = vx_r;
        mul_req.b = vy_r;
      end
      default: begin
        mul_req.a = '0;
        mul_req.b = '0;
      end
    endcase
  end
  assign mul_req.start = start_r;

  // Restoring division: quotient = floor(c^2 * 2^32 / (vx * vy)), at most 2^32.
  assign p_ext   = {1'b0, p_r};
  assign div_sh  = (step_r == '0) ? rem_r : {rem_r[REM_W-2:0], 1'b0};
  assign div_ge  = (div_sh >= p_ext);
  assign div_dif = div_sh - p_ext;

  // Integer square root, two radicand bits per step.
  assign sq_cur    = {srem_r, rad_r[RAD_W-1:RAD_W-2]};
  assign sq_trial  = (SR_W+2)'({root_r, 2'b01});
  assign sq_ge     = (sq_cur >= sq_trial);
  assign sq_dif    = sq_cur - sq_trial;
  assign root_step = {root_r[ROOT_W-2:0], sq_ge};
  // The result m is the largest value with (2m-1) at most the root.
  assign root_inc  = {1'b0, root_step} + 1'b1;
  assign m_pos     = root_inc[ROOT_W:1];
  assign m_neg     = ~m_pos + 1'b1;

  assign pair_ready = (state_r == ST_ACC);
  assign pop        = pair_valid && pair_ready;

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    start_nxt     = 1'b0;
    cnt_nxt       = cnt_r;
    sx_nxt        = sx_r;
    sy_nxt        = sy_r;
    sxx_nxt       = sxx_r;
    syy_nxt       = syy_r;
    sxy_nxt       = sxy_r;
    t0_nxt        = t0_r;
    vx_nxt        = vx_r;
    vy_nxt        = vy_r;
    c_nxt         = c_r;
    c2_nxt        = c2_r;
    p_nxt         = p_r;
    rem_nxt       = rem_r;
    quo_nxt       = quo_r;
    rad_nxt       = rad_r;
    srem_nxt      = srem_r;
    root_nxt      = root_r;
    step_nxt      = step_r;
    res_corr_nxt  = res_corr_r;
    res_zv_nxt    = res_zv_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_corr_nxt  = out_corr_r;
    out_zv_nxt    = out_zv_r;

    case (state_r)
      ST_ACC: begin
        if (pop) begin
          // Pairs past the length limit are dropped from the sums.
          if (cnt_r < CNT_W'(MAX_LENGTH)) begin
            cnt_nxt = cnt_r + 1'b1;
            sx_nxt  = sx_r + SX_W'(pair_i.x);
            sy_nxt  = sy_r + SX_W'(pair_i.y);
            sxx_nxt = sxx_r + SXX_W'(pair_i.xx);
            syy_nxt = syy_r + SXX_W'(pair_i.yy);
            sxy_nxt = sxy_r + SXY_W'(pair_i.xy);
          end
          if (pair_i.last) begin
            state_nxt = ST_MUL;
            op_nxt    = OP_N_SXX;
            start_nxt = 1'b1;
          end
        end
      end
      ST_MUL: begin
        if (mul_rsp.done) begin
          start_nxt = 1'b1;
          op_nxt    = mul_op_t'(op_r + 3'd1);
          case (op_r)
            OP_N_SXX: t0_nxt = p64;
            OP_SX_SX: vx_nxt = t0_r - p64;
            OP_N_SYY: t0_nxt = p64;
            OP_SY_SY: vy_nxt = t0_r - p64;
            OP_N_SXY: t0_nxt = sxy_r[SXY_W-1] ? p_neg : p64;
            OP_SX_SY: begin
              c_nxt = t0_r - ((sx_r[SX_W-1] ^ sy_r[SX_W-1]) ? p_neg : p64);
              if (vx_r == '0 || vy_r == '0) begin
                start_nxt    = 1'b0;
                res_corr_nxt = '0;
                res_zv_nxt   = 1'b1;
                state_nxt    = ST_DONE;
              end
            end
            OP_C_C: c2_nxt = mul_rsp.p[PQ_W-1:0];
            OP_VX_VY: begin
              start_nxt = 1'b0;
              p_nxt     = mul_rsp.p[PQ_W-1:0];
              rem_nxt   = {1'b0, c2_r};
              quo_nxt   = '0;
              step_nxt  = '0;
              state_nxt = ST_DIV;
            end
            default: start_nxt = 1'b0;
          endcase
        end
      end
      ST_DIV: begin
        rem_nxt  = div_ge ? div_dif : div_sh;
        quo_nxt  = {quo_r[QUO_W-2:0], div_ge};
        step_nxt = step_r + 1'b1;
        if (step_r == STEP_W'(QUO_W - 1)) begin
          rad_nxt   = {1'b0, quo_r[QUO_W-2:0], div_ge};
          srem_nxt  = '0;
          root_nxt  = '0;
          step_nxt  = '0;
          state_nxt = ST_SQRT;
        end
      end
      ST_SQRT: begin
        srem_nxt = sq_ge ? sq_dif[SR_W-1:0] : sq_cur[SR_W-1:0];
        root_nxt = root_step;
        rad_nxt  = {rad_r[RAD_W-3:0], 2'b00};
        step_nxt = step_r + 1'b1;
        if (step_r == STEP_W'(ROOT_W - 1)) begin
          res_zv_nxt = 1'b0;
          if (c_r[WORD_W-1]) begin
            res_corr_nxt = m_neg[OUT_W-1:0];
          end else if (m_pos > ROOT_W'(Q15_MAX)) begin
            res_corr_nxt = Q15_MAX;
          end else begin
            res_corr_nxt = m_pos[OUT_W-1:0];
          end
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_corr_nxt  = res_corr_r;
          out_zv_nxt    = res_zv_r;
          cnt_nxt       = '0;
          sx_nxt        = '0;
          sy_nxt        = '0;
          sxx_nxt       = '0;
          syy_nxt       = '0;
          sxy_nxt       = '0;
          state_nxt     = ST_ACC;
        end
      end
      default: state_nxt = ST_ACC;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_ACC;
      op_r        <= OP_N_SXX;
      start_r     <= 1'b0;
      cnt_r       <= '0;
      sx_r        <= '0;
      sy_r        <= '0;
      sxx_r       <= '0;
      syy_r       <= '0;
      sxy_r       <= '0;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      op_r        <= op_nxt;
      start_r     <= start_nxt;
      cnt_r       <= cnt_nxt;
      sx_r        <= sx_nxt;
      sy_r        <= sy_nxt;
      sxx_r       <= sxx_nxt;
      syy_r       <= syy_nxt;
      sxy_r       <= sxy_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    t0_r       <= t0_nxt;
    vx_r       <= vx_nxt;
    vy_r       <= vy_nxt;
    c_r        <= c_nxt;
    c2_r       <= c2_nxt;
    p_r        <= p_nxt;
    rem_r      <= rem_nxt;
    quo_r      <= quo_nxt;
    rad_r      <= rad_nxt;
    srem_r     <= srem_nxt;
    root_r     <= root_nxt;
    res_corr_r <= res_corr_nxt;
    res_zv_r   <= res_zv_nxt;
    out_corr_r <= out_corr_nxt;
    out_zv_r   <= out_zv_nxt;
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.correlation   = out_corr_r;
  assign out_ch.zero_variance = out_zv_r;

endmodule

[sv/pearson_correlation_top.sv]
// Pearson correlation over a stream of signed sample pairs. Pairs are taken one per cycle
// while the back end accumulates, and summed into the count and the sums of x, y, x*x,
// y*y and x*y; negate_first flips the sign of every x. The pair marked last_pair closes
// the vector: the block then computes the final result (up to eight 64-bit products on
// one 32x32 multiplier, then a 33-bit restoring division and a 17-bit square root),
// during which further pairs fill the two-entry queue and then wait. The result is the
// coefficient in Q1.15, rounded to nearest and saturated, or 0 with zero_variance set
// when either variance term is zero. A finished result waits in the output register
// while the next vector streams in.
module pearson_correlation_top #(
  parameter int MAX_LENGTH  = 65536,
  parameter int SAMPLE_BITS = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  pcc_in_if.sink     in_ch,
  pcc_out_if.source  out_ch,
  pcc_cfg_if.sink    cfg_ch
);
  import pcc_pkg::*;

  localparam int CNT_W = $clog2(MAX_LENGTH + 1);

  logic     negate_r, negate_nxt;
  pair_t    front_pair, queue_pair;
  logic     front_valid, front_ready, queue_valid, queue_ready;
  mul_req_t mul_req;
  mul_rsp_t mul_rsp;

  assign cfg_ch.ready = 1'b1;
  assign negate_nxt   = (cfg_ch.valid && cfg_ch.ready) ? cfg_ch.negate_first : negate_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      negate_r <= 1'b0;
    end else begin
      negate_r <= negate_nxt;
    end
  end

  pcc_front #(.SAMPLE_BITS(SAMPLE_BITS)) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_ch        (in_ch),
    .negate_first (negate_r),
    .pair_o       (front_pair),
    .pair_valid   (front_valid),
    .pair_ready   (front_ready)
  );

  pcc_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_data  (front_pair),
    .wr_valid (front_valid),
    .wr_ready (front_ready),
    .rd_data  (queue_pair),
    .rd_valid (queue_valid),
    .rd_ready (queue_ready)
  );

  pcc_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mul_req),
    .rsp   (mul_rsp)
  );

  pcc_back #(.MAX_LENGTH(MAX_LENGTH), .CNT_W(CNT_W)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .pair_i     (queue_pair),
    .pair_valid (queue_valid),
    .pair_ready (queue_ready),
    .mul_req    (mul_req),
    .mul_rsp    (mul_rsp),
    .out_ch     (out_ch)
  );

endmodule
